// ----- rtl/iir_df_pkg.sv -----
`timescale 1ns / 1ps

package iir_df_pkg;

	localparam int MAX_TAPS_DEF    = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEFF_BITS_DEF  = 18;
	localparam int FRAC_BITS_DEF   = 14;

	localparam int MODE_BITS      = 2;
	localparam int COEFF_IDX_BITS = 4;
	localparam int TAPS_BITS      = 5;
	localparam int CFG_IDX_BITS   = 1;
	localparam int ACC_BITS       = 64;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_SAMPLE   = 2'd0,
		MODE_LOAD_NUM = 2'd1,
		MODE_LOAD_DEN = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_TAPS = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DEN_TAPS = 1'b1;

	typedef logic [2:0] upc_t;

	localparam upc_t U_IDLE  = 3'd0;
	localparam upc_t U_NUM   = 3'd1;
	localparam upc_t U_DEN   = 3'd2;
	localparam upc_t U_DRAIN = 3'd3;
	localparam upc_t U_FIN   = 3'd4;

	typedef struct packed {
		logic wait_in;
		logic issue;
		logic sel_den;
		logic init_den;
		logic finish;
		upc_t jmp_t;
		upc_t jmp_f;
	} ucode_t;

	// control store
	function automatic ucode_t ucode_rom(input upc_t upc);
		ucode_t w;
		begin
			w = '0;
			unique case (upc)
				U_IDLE: begin
					w.wait_in = 1'b1;
					w.jmp_t   = U_NUM;
					w.jmp_f   = U_IDLE;
				end
				U_NUM: begin
					w.issue    = 1'b1;
					w.init_den = 1'b1;
					w.jmp_t    = U_NUM;
					w.jmp_f    = U_DEN;
				end
				U_DEN: begin
					w.issue   = 1'b1;
					w.sel_den = 1'b1;
					w.jmp_t   = U_DEN;
					w.jmp_f   = U_DRAIN;
				end
				U_DRAIN: begin
					w.jmp_t = U_FIN;
					w.jmp_f = U_FIN;
				end
				U_FIN: begin
					w.finish = 1'b1;
					w.jmp_t  = U_IDLE;
					w.jmp_f  = U_FIN;
				end
				default: begin
					w.jmp_t = U_IDLE;
					w.jmp_f = U_IDLE;
				end
			endcase
			return w;
		end
	endfunction

endpackage

// ----- rtl/iir_df_ifs.sv -----
`timescale 1ns / 1ps

interface iir_df_in_if #(
	parameter int SAMPLE_BITS = iir_df_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = iir_df_pkg::COEFF_BITS_DEF
);
	logic                                    valid;
	logic                                    ready;
	logic [iir_df_pkg::MODE_BITS-1:0]        mode;
	logic signed [SAMPLE_BITS-1:0]           sample;
	logic [iir_df_pkg::COEFF_IDX_BITS-1:0]   coeff_index;
	logic signed [COEFF_BITS-1:0]            coeff_value;

	modport source (output valid, mode, sample, coeff_index, coeff_value, input ready);
	modport sink   (input valid, mode, sample, coeff_index, coeff_value, output ready);
endinterface

interface iir_df_out_if #(
	parameter int SAMPLE_BITS = iir_df_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered_sample;
	logic                          saturated;

	modport source (output valid, filtered_sample, saturated, input ready);
	modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

// ----- rtl/iir_direct_form_filter_top.sv -----
// samples: one at a time; a new sample is accepted only once the previous result is registered
//   at the output, as the shared multiply-accumulate takes one tap per cycle under the
//   microcode sequencer
// coefficient loads: one per cycle while the sequencer is idle
// reset: sequencer idle, taps 1/1, history position 0, stores read as zero
`timescale 1ns / 1ps

module iir_direct_form_filter_top #(
	parameter int MAX_TAPS    = iir_df_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS = iir_df_pkg::SAMPLE_BITS_DEF,
	parameter int COEFF_BITS  = iir_df_pkg::COEFF_BITS_DEF,
	parameter int FRAC_BITS   = iir_df_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	iir_df_in_if.sink                             in_ch,
	iir_df_out_if.source                          out_ch,
	input  logic                                  cfg_we,
	input  logic [iir_df_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [iir_df_pkg::TAPS_BITS-1:0]      cfg_wdata
);
	import iir_df_pkg::*;

	localparam int AW = $clog2(MAX_TAPS);
	localparam int CW = $clog2(MAX_TAPS + 1);
	localparam int PW = COEFF_BITS + SAMPLE_BITS;
	localparam logic signed [ACC_BITS-1:0] Y_MAX =
		(ACC_BITS'(64'sd1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(64'sd1);
	localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - ACC_BITS'(64'sd1);

	// configuration
	logic [TAPS_BITS-1:0] num_taps_q;
	logic [TAPS_BITS-1:0] den_taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= TAPS_BITS'(1);
			den_taps_q <= TAPS_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_TAPS: num_taps_q <= cfg_wdata;
				REG_DEN_TAPS: den_taps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [CW-1:0] nt_eff;
	logic [CW-1:0] dt_eff;

	always_comb begin
		if (32'(num_taps_q) > 32'(MAX_TAPS)) nt_eff = CW'(MAX_TAPS);
		else nt_eff = CW'(num_taps_q);
		if (32'(den_taps_q) > 32'(MAX_TAPS)) dt_eff = CW'(MAX_TAPS);
		else dt_eff = CW'(den_taps_q);
	end

	// sequencer
	upc_t   upc_q;
	ucode_t uw;
	logic [CW-1:0] i_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] pos_q;
	logic          in_acc;
	logic          smp_acc;
	logic          coef_ok;
	logic          ld_num;
	logic          ld_den;
	logic [AW-1:0] wr_idx;
	logic          tap_more;
	logic          out_free;
	logic          cond;
	logic          fin_go;
	logic [AW-1:0] slot_dec;
	logic [AW-1:0] pos_dec;
	logic [AW-1:0] pos_inc;

	assign uw       = ucode_rom(upc_q);
	assign in_ch.ready = uw.wait_in;
	assign in_acc   = in_ch.valid & in_ch.ready;
	assign smp_acc  = in_acc & (in_ch.mode == MODE_SAMPLE);
	assign coef_ok  = 32'(in_ch.coeff_index) < 32'(MAX_TAPS);
	assign ld_num   = in_acc & (in_ch.mode == MODE_LOAD_NUM) & coef_ok;
	assign ld_den   = in_acc & (in_ch.mode == MODE_LOAD_DEN) & coef_ok;
	assign wr_idx   = AW'(in_ch.coeff_index);
	assign tap_more = i_q < (uw.sel_den ? dt_eff : nt_eff);
	assign out_free = !out_ch.valid || out_ch.ready;
	assign cond     = (uw.wait_in & smp_acc) | (uw.issue & tap_more) |
		(uw.finish & out_free) | ~(uw.wait_in | uw.issue | uw.finish);
	assign fin_go   = uw.finish & out_free;
	assign slot_dec = (slot_q == '0) ? AW'(MAX_TAPS - 1) : slot_q - AW'(1);
	assign pos_dec  = (pos_q == '0) ? AW'(MAX_TAPS - 1) : pos_q - AW'(1);
	assign pos_inc  = (pos_q == AW'(MAX_TAPS - 1)) ? '0 : pos_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q  <= U_IDLE;
			i_q    <= '0;
			slot_q <= '0;
			pos_q  <= '0;
		end else begin
			upc_q <= cond ? uw.jmp_t : uw.jmp_f;
			if (uw.wait_in && smp_acc) begin
				i_q    <= '0;
				slot_q <= pos_q;
			end else if (uw.issue && tap_more) begin
				i_q    <= i_q + CW'(1);
				slot_q <= slot_dec;
			end else if (uw.init_den) begin
				i_q    <= CW'(1);
				slot_q <= pos_dec;
			end
			if (fin_go) pos_q <= pos_inc;
		end
	end

	// stores with valid bits, unwritten entries read as zero
	logic signed [COEFF_BITS-1:0]  num_mem [MAX_TAPS];
	logic signed [COEFF_BITS-1:0]  den_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] x_mem   [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] y_mem   [MAX_TAPS];
	logic [MAX_TAPS-1:0] num_vld_q;
	logic [MAX_TAPS-1:0] den_vld_q;
	logic [MAX_TAPS-1:0] x_vld_q;
	logic [MAX_TAPS-1:0] y_vld_q;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	always_ff @(posedge clk) begin
		if (ld_num) num_mem[wr_idx] <= in_ch.coeff_value;
		if (ld_den) den_mem[wr_idx] <= in_ch.coeff_value;
		if (smp_acc) x_mem[pos_q] <= in_ch.sample;
		if (fin_go) y_mem[pos_q] <= y_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vld_q <= '0;
			den_vld_q <= '0;
			x_vld_q   <= '0;
			y_vld_q   <= '0;
		end else begin
			if (ld_num) num_vld_q[wr_idx] <= 1'b1;
			if (ld_den) den_vld_q[wr_idx] <= 1'b1;
			if (smp_acc) x_vld_q[pos_q] <= 1'b1;
			if (fin_go) y_vld_q[pos_q] <= 1'b1;
		end
	end

	// tap pipeline: read, multiply, accumulate
	logic [AW-1:0] c_addr;
	logic signed [COEFF_BITS-1:0]  num_rd_s1;
	logic signed [COEFF_BITS-1:0]  den_rd_s1;
	logic signed [SAMPLE_BITS-1:0] x_rd_s1;
	logic signed [SAMPLE_BITS-1:0] y_rd_s1;
	logic tap_s1;
	logic sub_s1;
	logic signed [PW-1:0] prod_s2;
	logic tap_s2;
	logic sub_s2;
	logic signed [ACC_BITS-1:0] acc_q;
	logic signed [ACC_BITS-1:0] prod_ext;
	logic signed [ACC_BITS-1:0] y_full;

	assign c_addr = i_q[AW-1:0];

	always_ff @(posedge clk) begin
		num_rd_s1 <= num_vld_q[c_addr] ? num_mem[c_addr] : '0;
		den_rd_s1 <= den_vld_q[c_addr] ? den_mem[c_addr] : '0;
		x_rd_s1   <= x_vld_q[slot_q] ? x_mem[slot_q] : '0;
		y_rd_s1   <= y_vld_q[slot_q] ? y_mem[slot_q] : '0;
		sub_s1    <= uw.sel_den;
		prod_s2   <= sub_s1 ? den_rd_s1 * y_rd_s1 : num_rd_s1 * x_rd_s1;
		sub_s2    <= sub_s1;
	end

	assign prod_ext = ACC_BITS'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
			acc_q  <= '0;
		end else begin
			tap_s1 <= uw.issue & tap_more;
			tap_s2 <= tap_s1;
			if (uw.wait_in && smp_acc) acc_q <= '0;
			else if (tap_s2) acc_q <= sub_s2 ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	// scale and clip
	logic y_clip;

	assign y_full = acc_q >>> FRAC_BITS;

	always_comb begin
		y_clip = 1'b1;
		if (y_full > Y_MAX) y_sat = SAMPLE_BITS'(Y_MAX);
		else if (y_full < Y_MIN) y_sat = SAMPLE_BITS'(Y_MIN);
		else begin
			y_sat  = SAMPLE_BITS'(y_full);
			y_clip = 1'b0;
		end
	end

	// output register
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_smp_q;
	logic                          out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (fin_go) out_vld_q <= 1'b1;
		else if (out_ch.ready) out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_smp_q <= y_sat;
			out_sat_q <= y_clip;
		end
	end

	assign out_ch.valid           = out_vld_q;
	assign out_ch.filtered_sample = out_smp_q;
	assign out_ch.saturated       = out_sat_q;

endmodule
